>>> design/iltok_pkg.sv
// Shared types, byte codes and helpers for the IRC line tokenizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package iltok_pkg;

  localparam int unsigned ILTOK_TOKEN_INDEX_LIMIT = 63;
  localparam int unsigned TOK_W = 6;
  localparam logic [TOK_W-1:0] TOK_MAX = '1;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [5:0] {
    SEC_START      = 6'b000001,
    SEC_TAG        = 6'b000010,
    SEC_AFTER_TAGS = 6'b000100,
    SEC_SOURCE     = 6'b001000,
    SEC_PARAMS     = 6'b010000,
    SEC_TRAILING   = 6'b100000
  } iltok_sec_t;

  typedef enum logic [3:0] {
    CLS_TAG_MARK   = 4'd0,
    CLS_TAG_NAME   = 4'd1,
    CLS_EQUALS     = 4'd2,
    CLS_TAG_VALUE  = 4'd3,
    CLS_SEMICOLON  = 4'd4,
    CLS_SEC_SPACE  = 4'd5,
    CLS_SRC_COLON  = 4'd6,
    CLS_NICK       = 4'd7,
    CLS_BANG       = 4'd8,
    CLS_USER       = 4'd9,
    CLS_AT         = 4'd10,
    CLS_HOST       = 4'd11,
    CLS_PARAM      = 4'd12,
    CLS_PARAM_SP   = 4'd13,
    CLS_TRAIL_COL  = 4'd14,
    CLS_TRAIL_BYTE = 4'd15
  } iltok_cls_t;

  typedef enum logic [1:0] {
    FORM_NONE  = 2'd0,
    FORM_PLAIN = 2'd1,
    FORM_NAME  = 2'd2,
    FORM_FULL  = 2'd3
  } iltok_form_t;

  typedef struct packed {
    iltok_sec_t       sec;
    logic [TOK_W-1:0] tok;
    logic [TOK_W-1:0] pend;
    logic             bang;
    logic             at;
    logic             tv;
  } iltok_state_t;

  typedef struct packed {
    iltok_cls_t       cls;
    logic [TOK_W-1:0] idx;
    iltok_form_t      form;
    logic             last;
  } iltok_res_t;

  localparam iltok_state_t STATE_RST = '{
    sec: SEC_START, tok: '0, pend: '0, bang: 1'b0, at: 1'b0, tv: 1'b0
  };

  function automatic logic [TOK_W-1:0] sat_add(
    input logic [TOK_W-1:0] a,
    input logic [TOK_W-1:0] b,
    input logic [TOK_W-1:0] lim
  );
    logic [TOK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = (s > {1'b0, lim}) ? lim : s[TOK_W-1:0];
  endfunction

  function automatic iltok_form_t form_of(input logic bang, input logic at);
    form_of = bang ? FORM_FULL : (at ? FORM_NAME : FORM_PLAIN);
  endfunction

endpackage

`default_nettype wire

>>> design/iltok_classify.sv
// Per-byte classifier: next tokenizer state and result from current state.
// Depends on iltok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iltok_classify
  import iltok_pkg::*;
#(
  parameter int unsigned TOKEN_INDEX_LIMIT = ILTOK_TOKEN_INDEX_LIMIT
) (
  input  iltok_state_t st_i,
  input  logic [7:0]   byte_i,
  input  logic         eol_i,
  output iltok_state_t st_nxt,
  output iltok_res_t   res_o
);

  localparam int unsigned EffLim = (TOKEN_INDEX_LIMIT > 63) ? 63 : TOKEN_INDEX_LIMIT;
  localparam logic [TOK_W-1:0] TokLim = TOK_W'(EffLim);

  iltok_state_t s;
  iltok_cls_t   cls;
  logic [TOK_W-1:0] idx;
  iltok_form_t  form;

  always_comb begin
    s    = st_i;
    cls  = CLS_TAG_MARK;
    idx  = '0;
    form = FORM_NONE;
    if (st_i.sec == SEC_START && byte_i == CH_AT) begin
      s.tok = '0;
      s.tv  = 1'b0;
      s.sec = SEC_TAG;
    end else begin
      unique case (st_i.sec)
        SEC_TAG: begin
          idx = st_i.tok;
          if (byte_i == CH_SPACE) begin
            cls   = CLS_SEC_SPACE;
            s.sec = SEC_AFTER_TAGS;
          end else if (byte_i == CH_SEMI) begin
            cls   = CLS_SEMICOLON;
            s.tok = sat_add(st_i.tok, TOK_W'(1), TokLim);
            s.tv  = 1'b0;
          end else if (byte_i == CH_EQ && !st_i.tv) begin
            cls  = CLS_EQUALS;
            s.tv = 1'b1;
          end else begin
            cls = st_i.tv ? CLS_TAG_VALUE : CLS_TAG_NAME;
          end
        end
        SEC_SOURCE: begin
          if (byte_i == CH_SPACE) begin
            cls    = CLS_SEC_SPACE;
            s.sec  = SEC_PARAMS;
            s.tok  = '0;
            s.pend = '0;
          end else if (byte_i == CH_BANG && !st_i.bang && !st_i.at) begin
            cls    = CLS_BANG;
            s.bang = 1'b1;
          end else if (byte_i == CH_AT && !st_i.at) begin
            cls  = CLS_AT;
            s.at = 1'b1;
          end else if (st_i.at) begin
            cls = CLS_HOST;
          end else if (st_i.bang) begin
            cls = CLS_USER;
          end else begin
            cls = CLS_NICK;
          end
          if (byte_i == CH_SPACE || eol_i) begin
            form = form_of(s.bang, s.at);
          end
        end
        SEC_PARAMS: begin
          if (byte_i == CH_SPACE) begin
            cls    = CLS_PARAM_SP;
            s.pend = (st_i.pend != TOK_MAX) ? st_i.pend + TOK_W'(1) : st_i.pend;
            idx    = st_i.tok;
          end else begin
            s.tok  = sat_add(st_i.tok, st_i.pend, TokLim);
            s.pend = '0;
            idx    = s.tok;
            if (byte_i == CH_COLON) begin
              cls   = CLS_TRAIL_COL;
              s.sec = SEC_TRAILING;
            end else begin
              cls = CLS_PARAM;
            end
          end
        end
        SEC_TRAILING: begin
          cls = CLS_TRAIL_BYTE;
          idx = st_i.tok;
        end
        default: begin
          // line start without tags, right after the tag section
          s.tok  = '0;
          s.pend = '0;
          if (byte_i == CH_COLON) begin
            cls    = CLS_SRC_COLON;
            s.bang = 1'b0;
            s.at   = 1'b0;
            s.sec  = SEC_SOURCE;
            if (eol_i) begin
              form = FORM_PLAIN;
            end
          end else begin
            s.sec = SEC_PARAMS;
            if (byte_i == CH_SPACE) begin
              cls    = CLS_PARAM_SP;
              s.pend = TOK_W'(1);
            end else begin
              cls = CLS_PARAM;
            end
          end
        end
      endcase
    end
    st_nxt = eol_i ? STATE_RST : s;
  end

  assign res_o = '{cls: cls, idx: idx, form: form, last: eol_i};

endmodule

`default_nettype wire

>>> design/iltok_skid.sv
// Result register with a skid stage, decoupling input ready from output ready.
// Depends on iltok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iltok_skid
  import iltok_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_i,
  input  iltok_res_t push_data_i,
  output logic       ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output iltok_res_t out_data_o
);

  logic       main_valid_r;
  iltok_res_t main_data_r;
  logic       skid_valid_r;
  iltok_res_t skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || out_ready_i) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push_i;
      end
    end else if (push_i) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || out_ready_i) begin
      main_data_r <= skid_valid_r ? skid_data_r : push_data_i;
    end else if (push_i) begin
      skid_data_r <= push_data_i;
    end
  end

  assign ready_o     = !skid_valid_r;
  assign out_valid_o = main_valid_r;
  assign out_data_o  = main_data_r;

endmodule

`default_nettype wire

>>> design/irc_line_tokenizer_unit.sv
// Top level of the IRC line tokenizer: state registers, classifier, result skid.
// Depends on iltok_pkg, iltok_classify and iltok_skid.
`timescale 1ns / 1ps
`default_nettype none

// Classifies an IRC message line one byte per request, one result per byte, in order.
// The block sustains one byte per cycle while out_tready holds: the tokenizer state
// is registered on acceptance, and the result goes to the output register, or to the
// skid stage while the output stalls. A skid stage behind the output register keeps
// the input ready for one more byte while a result waits. in_tlast marks the final
// byte of a line; after it all state returns to line start. The token index saturates
// at TOKEN_INDEX_LIMIT (values above 63 act as 63).
module irc_line_tokenizer_unit
  import iltok_pkg::*;
#(
  parameter int unsigned TOKEN_INDEX_LIMIT = ILTOK_TOKEN_INDEX_LIMIT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] line_byte
  input  logic       in_tlast,   // end_of_line
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [5:0] token_index, [7:6] source_form
  output logic [3:0] out_tuser,  // [3:0] field_class
  output logic       out_tlast   // last_of_line
);

  localparam int unsigned EffLim = (TOKEN_INDEX_LIMIT > 63) ? 63 : TOKEN_INDEX_LIMIT;

  iltok_state_t st_r;
  iltok_state_t st_nxt;
  iltok_res_t   res;
  iltok_res_t   out_res;
  logic         in_acc;

  assign in_acc = in_tvalid && in_tready;

  iltok_classify #(
    .TOKEN_INDEX_LIMIT(TOKEN_INDEX_LIMIT)
  ) u_classify (
    .st_i   (st_r),
    .byte_i (in_tdata),
    .eol_i  (in_tlast),
    .st_nxt (st_nxt),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RST;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  iltok_skid u_skid (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (in_acc),
    .push_data_i (res),
    .ready_o     (in_tready),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (out_res)
  );

  assign out_tdata = {out_res.form, out_res.idx};
  assign out_tuser = out_res.cls;
  assign out_tlast = out_res.last;

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> st_r.sec == SEC_START && st_r.tok == '0 && st_r.pend == '0)
    else $error("state not cleared after end of line");

  a_tok_limit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.tok <= TOK_W'(EffLim))
    else $error("token count above limit");

  a_form_source_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:6] != FORM_NONE |->
      out_tuser >= CLS_SEC_SPACE && out_tuser <= CLS_HOST)
    else $error("source form on a non-source byte");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && in_acc |=> !in_tready)
    else $error("input ready while both result slots full");

endmodule

`default_nettype wire
